// File: design/cppm_frame_decoder_unit_defines.svh
// Assertion helpers shared by the decoder RTL.
`ifndef CPPM_FRAME_DECODER_UNIT_DEFINES_SVH
`define CPPM_FRAME_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CPPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/cppm_pkg.sv
package cppm_pkg;

	localparam int CHANNELS_DEFAULT = 6;
	localparam int AUX_SLOT_DEFAULT = 4;

	localparam int TIME_W = 16;
	localparam int SLOT_W = 5;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [TIME_W-1:0] SYNC_MIN_RESET = 16'd8000;
	localparam logic [TIME_W-1:0] SYNC_MAX_RESET = 16'd18000;

	// Aux channel thresholds, in microseconds.
	localparam logic [TIME_W-1:0] AUX_LOST_WIDTH  = 16'd1300;
	localparam logic [TIME_W-1:0] AUX_FAULT_LOW   = 16'd1200;
	localparam logic [TIME_W-1:0] AUX_CALIB_LOW   = 16'd1700;
	localparam logic [TIME_W-1:0] AUX_CALIB_HIGH  = 16'd2000;

	// Register index, taken from paddr bit 2.
	localparam logic REG_SYNC_MIN = 1'b0;
	localparam logic REG_SYNC_MAX = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0] last_capture;
		logic [SLOT_W-1:0] slot_count;
		logic              frame_locked;
		logic [TIME_W-1:0] aux_width;
	} cppm_state_t;

	typedef struct packed {
		logic [TIME_W-1:0] interval;
		logic [SLOT_W-1:0] slot;
		logic              width_valid;
		logic              frame_done;
		logic              sync_lost;
		logic              locked;
		logic              link_fault;
		logic              calibrate_request;
	} cppm_result_t;

endpackage

// File: design/cppm_step.sv
module cppm_step #(
	parameter int CHANNELS = cppm_pkg::CHANNELS_DEFAULT,
	parameter int AUX_SLOT = cppm_pkg::AUX_SLOT_DEFAULT
) (
	input  cppm_pkg::cppm_state_t              state,
	input  logic [cppm_pkg::TIME_W-1:0]        edge_time,
	input  logic [cppm_pkg::TIME_W-1:0]        sync_min,
	input  logic [cppm_pkg::TIME_W-1:0]        sync_max,
	output cppm_pkg::cppm_state_t              state_next,
	output cppm_pkg::cppm_result_t             result
);

	localparam logic [cppm_pkg::SLOT_W-1:0] LAST_SLOT = cppm_pkg::SLOT_W'(CHANNELS - 1);
	localparam logic [cppm_pkg::SLOT_W-1:0] NO_SLOT   = cppm_pkg::SLOT_W'(CHANNELS);
	localparam logic [cppm_pkg::SLOT_W-1:0] AUX_IDX   = cppm_pkg::SLOT_W'(AUX_SLOT);

	logic [cppm_pkg::TIME_W-1:0] diff;
	logic                        in_window;

	assign diff      = state.last_capture - edge_time;
	assign in_window = (diff > sync_min) && (diff < sync_max);

	always_comb begin
		state_next              = state;
		state_next.last_capture = edge_time;
		result                  = '0;
		result.interval         = diff;
		result.slot             = NO_SLOT;

		if (state.frame_locked) begin
			if (state.slot_count <= LAST_SLOT) begin
				result.slot        = state.slot_count;
				result.width_valid = 1'b1;
				if (state.slot_count == AUX_IDX) begin
					state_next.aux_width = diff;
				end
				if (state.slot_count == LAST_SLOT) begin
					result.frame_done = 1'b1;
				end
				state_next.slot_count = state.slot_count + 1'b1;
			end else if (in_window) begin
				state_next.slot_count = '0;
			end else begin
				state_next.frame_locked = 1'b0;
				state_next.aux_width    = cppm_pkg::AUX_LOST_WIDTH;
				result.sync_lost        = 1'b1;
			end
		end else if (in_window) begin
			state_next.slot_count   = '0;
			state_next.frame_locked = 1'b1;
		end

		result.locked = state_next.frame_locked;

		// The aux flags look at the width after this beat's update.
		result.calibrate_request = (state_next.aux_width > cppm_pkg::AUX_CALIB_LOW) &&
		                           (state_next.aux_width < cppm_pkg::AUX_CALIB_HIGH);
		result.link_fault        = ((state_next.aux_width > cppm_pkg::AUX_FAULT_LOW) &&
		                            (state_next.aux_width < cppm_pkg::AUX_CALIB_LOW)) ||
		                           result.calibrate_request;
	end

endmodule

// File: design/cppm_frame_decoder_unit.sv
// Channel   Direction  Handshake            Beat contents
// in        sink       in_valid/in_ready    edge_time
// out       source     out_valid/out_ready  interval, slot, flags, aux status
// apb       slave      psel/penable         sync_min (0x0), sync_max (0x4)
//
// One capture per clock when the output does not stall: a beat is registered
// at the input, decoded from there, and its result sits in the output register.
// The decoder state advances only when the input stage moves into the output
// register, so a stall on out_ready holds both stages and backs up in_ready.
// arst_n clears the pipeline valids, the decoder state (hunting, aux 1300)
// and restores the sync window registers to 8000 and 18000.
`include "cppm_frame_decoder_unit_defines.svh"

module cppm_frame_decoder_unit #(
	parameter int CHANNELS = cppm_pkg::CHANNELS_DEFAULT,
	parameter int AUX_SLOT = cppm_pkg::AUX_SLOT_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [cppm_pkg::TIME_W-1:0]   edge_time,

	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [cppm_pkg::TIME_W-1:0]   interval,
	output logic [cppm_pkg::SLOT_W-1:0]   slot,
	output logic                          width_valid,
	output logic                          frame_done,
	output logic                          sync_lost,
	output logic                          locked,
	output logic                          link_fault,
	output logic                          calibrate_request,

	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cppm_pkg::APB_AW-1:0]   paddr,
	input  logic [cppm_pkg::APB_DW-1:0]   pwdata,
	output logic [cppm_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	logic [cppm_pkg::TIME_W-1:0] sync_min_q;
	logic [cppm_pkg::TIME_W-1:0] sync_max_q;
	logic                        cfg_write;

	logic                        valid_s1;
	logic [cppm_pkg::TIME_W-1:0] edge_s1;
	logic                        adv_s1;

	logic                        valid_s2;
	cppm_pkg::cppm_result_t      result_s2;

	cppm_pkg::cppm_state_t       state_q;
	cppm_pkg::cppm_state_t       state_next;
	cppm_pkg::cppm_result_t      result;

	// Configuration port.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_min_q <= cppm_pkg::SYNC_MIN_RESET;
			sync_max_q <= cppm_pkg::SYNC_MAX_RESET;
		end else if (cfg_write) begin
			case (paddr[2])
				cppm_pkg::REG_SYNC_MIN: sync_min_q <= pwdata[cppm_pkg::TIME_W-1:0];
				cppm_pkg::REG_SYNC_MAX: sync_max_q <= pwdata[cppm_pkg::TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			cppm_pkg::REG_SYNC_MIN:
				prdata = cppm_pkg::APB_DW'(sync_min_q);
			cppm_pkg::REG_SYNC_MAX:
				prdata = cppm_pkg::APB_DW'(sync_max_q);
			default:
				prdata = '0;
		endcase
	end

	// Pipeline control.
	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			edge_s1 <= edge_time;
		end
	end

	cppm_step #(
		.CHANNELS (CHANNELS),
		.AUX_SLOT (AUX_SLOT)
	) u_step (
		.state      (state_q),
		.edge_time  (edge_s1),
		.sync_min   (sync_min_q),
		.sync_max   (sync_max_q),
		.state_next (state_next),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.last_capture <= '0;
			state_q.slot_count   <= '0;
			state_q.frame_locked <= 1'b0;
			state_q.aux_width    <= cppm_pkg::AUX_LOST_WIDTH;
			valid_s2             <= 1'b0;
		end else if (adv_s1) begin
			state_q  <= state_next;
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= result;
		end
	end

	assign out_valid         = valid_s2;
	assign interval          = result_s2.interval;
	assign slot              = result_s2.slot;
	assign width_valid       = result_s2.width_valid;
	assign frame_done        = result_s2.frame_done;
	assign sync_lost         = result_s2.sync_lost;
	assign locked            = result_s2.locked;
	assign link_fault        = result_s2.link_fault;
	assign calibrate_request = result_s2.calibrate_request;

	// While hunting, the aux width always reads as signal lost.
	`CPPM_ASSERT_NOW(a_hunt_aux_lost, clk, arst_n, !state_q.frame_locked,
		state_q.aux_width == cppm_pkg::AUX_LOST_WIDTH, "aux width not lost while hunting")

	// The end of a frame is the last slot of a valid width.
	`CPPM_ASSERT_NOW(a_frame_done_slot, clk, arst_n, valid_s2 && result_s2.frame_done,
		result_s2.width_valid && (result_s2.slot == cppm_pkg::SLOT_W'(CHANNELS - 1)),
		"frame_done without last slot width")

	// Losing sync never coincides with a stored width and leaves the block unlocked.
	`CPPM_ASSERT_NOW(a_lost_unlocked, clk, arst_n, valid_s2 && result_s2.sync_lost,
		!result_s2.locked && !result_s2.width_valid, "sync_lost with lock or width")

	// A beat that moves into the output register updates the capture history.
	`CPPM_ASSERT_NEXT(a_capture_tracks, clk, arst_n, adv_s1,
		state_q.last_capture == $past(edge_s1), "last capture not updated")

endmodule

// File: tb/sv/cppm_tb_pkg.sv
package cppm_tb_pkg;
	import cppm_pkg::*;

	localparam int NUM_CH = CHANNELS_DEFAULT;
	localparam int AUX_CH = AUX_SLOT_DEFAULT;
	localparam int MAX_PRINTED = 40;

	class frame_scoreboard;
		logic [TIME_W-1:0] sync_min;
		logic [TIME_W-1:0] sync_max;
		logic [TIME_W-1:0] prev_capture;
		logic [SLOT_W-1:0] slot_count;
		logic              frame_locked;
		logic [TIME_W-1:0] aux_width;
		cppm_result_t      expected_q [$];
		int                mismatches;
		int                beats_checked;

		function new();
			sync_min = SYNC_MIN_RESET;
			sync_max = SYNC_MAX_RESET;
			prev_capture = '0;
			slot_count = '0;
			frame_locked = 1'b0;
			aux_width = AUX_LOST_WIDTH;
			mismatches = 0;
			beats_checked = 0;
		endfunction

		function void set_register(input logic index, input logic [TIME_W-1:0] value);
			if (index == REG_SYNC_MIN)
				sync_min = value;
			else
				sync_max = value;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function logic in_window(input logic [TIME_W-1:0] gap);
			return gap > sync_min && gap < sync_max;
		endfunction

		// Decodes one capture and queues the result beat it must produce.
		function void note_edge(input logic [TIME_W-1:0] now);
			cppm_result_t r;
			logic [TIME_W-1:0] gap;
			logic calib;
			gap = prev_capture - now;
			r = '0;
			r.interval = gap;
			r.slot = SLOT_W'(NUM_CH);
			if (frame_locked) begin
				if (slot_count <= NUM_CH - 1) begin
					r.slot = slot_count;
					r.width_valid = 1'b1;
					if (slot_count == AUX_CH)
						aux_width = gap;
					if (slot_count == NUM_CH - 1)
						r.frame_done = 1'b1;
					slot_count = slot_count + 1'b1;
				end else if (in_window(gap)) begin
					slot_count = '0;
				end else begin
					frame_locked = 1'b0;
					aux_width = AUX_LOST_WIDTH;
					r.sync_lost = 1'b1;
				end
			end else if (in_window(gap)) begin
				slot_count = '0;
				frame_locked = 1'b1;
			end
			prev_capture = now;
			// The aux flags reflect the width after this edge's update.
			calib = aux_width > AUX_CALIB_LOW && aux_width < AUX_CALIB_HIGH;
			r.calibrate_request = calib;
			r.link_fault = (aux_width > AUX_FAULT_LOW && aux_width < AUX_CALIB_LOW) || calib;
			r.locked = frame_locked;
			expected_q.push_back(r);
		endfunction

		task report(input string what);
			mismatches++;
			if (mismatches <= MAX_PRINTED)
				$display("beat %0d: %s", beats_checked, what);
		endtask

		task check_result(input cppm_result_t got);
			cppm_result_t want;
			beats_checked++;
			if (expected_q.size() == 0) begin
				report("result beat with no capture outstanding");
				return;
			end
			want = expected_q.pop_front();
			if (got.interval !== want.interval)
				report($sformatf("interval %0d, want %0d", got.interval, want.interval));
			if (got.slot !== want.slot)
				report($sformatf("slot %0d, want %0d", got.slot, want.slot));
			if (got.width_valid !== want.width_valid)
				report($sformatf("width_valid %b, want %b", got.width_valid, want.width_valid));
			if (got.frame_done !== want.frame_done)
				report($sformatf("frame_done %b, want %b", got.frame_done, want.frame_done));
			if (got.sync_lost !== want.sync_lost)
				report($sformatf("sync_lost %b, want %b", got.sync_lost, want.sync_lost));
			if (got.locked !== want.locked)
				report($sformatf("locked %b, want %b", got.locked, want.locked));
			if (got.link_fault !== want.link_fault)
				report($sformatf("link_fault %b, want %b", got.link_fault, want.link_fault));
			if (got.calibrate_request !== want.calibrate_request)
				report($sformatf("calibrate_request %b, want %b",
					got.calibrate_request, want.calibrate_request));
		endtask
	endclass

endpackage

// File: tb/sv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cppm_pkg::*;
	import cppm_tb_pkg::*;

	localparam logic [APB_AW-1:0] ADDR_SYNC_MIN = {REG_SYNC_MIN, 2'b00};
	localparam logic [APB_AW-1:0] ADDR_SYNC_MAX = {REG_SYNC_MAX, 2'b00};
	localparam int NUM_PHASES = 7;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [TIME_W-1:0] edge_time = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [TIME_W-1:0] interval;
	logic [SLOT_W-1:0] slot;
	logic              width_valid;
	logic              frame_done;
	logic              sync_lost;
	logic              locked;
	logic              link_fault;
	logic              calibrate_request;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	frame_scoreboard   sb;
	logic              no_idle = 1'b0;
	logic [TIME_W-1:0] last_sent = '0;
	int                phase_sent = 0;

	// Window settings per phase; phases 3, 4 and 5 are empty windows.
	logic [TIME_W-1:0] phase_min [NUM_PHASES] =
		'{16'd8000, 16'd0, 16'd3000, 16'd65535, 16'd1000, 16'd4000, 16'd8000};
	logic [TIME_W-1:0] phase_max [NUM_PHASES] =
		'{16'd18000, 16'd65535, 16'd5000, 16'd0, 16'd1001, 16'd4000, 16'd18000};
	int phase_len [NUM_PHASES] = '{160, 150, 160, 50, 50, 50, 150};

	logic [TIME_W-1:0] aux_marks [12] = '{
		AUX_FAULT_LOW - 16'd1, AUX_FAULT_LOW, AUX_FAULT_LOW + 16'd1,
		AUX_LOST_WIDTH - 16'd1, AUX_LOST_WIDTH, AUX_LOST_WIDTH + 16'd1,
		AUX_CALIB_LOW - 16'd1, AUX_CALIB_LOW, AUX_CALIB_LOW + 16'd1,
		AUX_CALIB_HIGH - 16'd1, AUX_CALIB_HIGH, AUX_CALIB_HIGH + 16'd1
	};

	cppm_frame_decoder_unit uut (.*);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 23);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_result({interval, slot, width_valid, frame_done, sync_lost, locked,
				link_fault, calibrate_request});
		end
	end

	// Entered and left just after a falling edge. Valid stays high into the
	// next beat unless the sender decides to idle first.
	task automatic send_edge(input logic [TIME_W-1:0] capture);
		while (!no_idle && $urandom_range(0, 99) < 23) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		edge_time <= capture;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_edge(capture);
		last_sent = capture;
		phase_sent++;
		@(negedge clk);
	endtask

	// The counter runs down, so a gap of N is a capture N below the last one.
	task automatic send_gap(input logic [TIME_W-1:0] gap);
		send_edge(last_sent - gap);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [TIME_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {16'($urandom()), value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_window(input logic [TIME_W-1:0] lo, input logic [TIME_W-1:0] hi);
		wait_drained();
		apb_write(ADDR_SYNC_MIN, lo);
		sb.set_register(REG_SYNC_MIN, lo);
		apb_write(ADDR_SYNC_MAX, hi);
		sb.set_register(REG_SYNC_MAX, hi);
	endtask

	function automatic logic [TIME_W-1:0] sync_gap();
		int lo;
		int hi;
		lo = sb.sync_min;
		hi = sb.sync_max;
		if (hi <= lo + 1)
			return 16'($urandom());
		case ($urandom_range(0, 9))
			0: return 16'(lo + 1);
			1: return 16'(hi - 1);
			default: return 16'($urandom_range(lo + 1, hi - 1));
		endcase
	endfunction

	function automatic logic [TIME_W-1:0] broken_gap();
		case ($urandom_range(0, 2))
			0: return sb.sync_min;
			1: return sb.sync_max;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [TIME_W-1:0] channel_width(input int ch);
		if (ch == AUX_CH && $urandom_range(0, 1))
			return aux_marks[$urandom_range(0, 11)];
		if ($urandom_range(0, 9) < 8)
			return 16'($urandom_range(900, 2100));
		return 16'($urandom());
	endfunction

	// Mostly whole frames with random widths; some with a bad sync gap, a few
	// bursts of unrelated captures.
	task automatic send_random_frame();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 6) begin
			repeat ($urandom_range(1, 4)) send_edge(16'($urandom()));
		end else begin
			if (roll < 14)
				send_gap(broken_gap());
			else
				send_gap(sync_gap());
			for (int ch = 0; ch < NUM_CH; ch++)
				send_gap(channel_width(ch));
		end
	endtask

	initial begin
		logic held;
		sb = new();
		held = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// First captures run against a previous value of zero and wrap.
		send_edge(16'hFFFF);
		send_edge(16'h0000);
		send_gap(16'd0);
		// Gaps on the window bounds do not lock.
		send_gap(SYNC_MIN_RESET);
		send_gap(SYNC_MAX_RESET);
		send_gap(SYNC_MIN_RESET + 16'd1);
		send_gap(16'd1000);
		send_gap(16'd2000);
		send_gap(16'd1500);
		send_gap(AUX_FAULT_LOW);
		send_gap(AUX_FAULT_LOW + 16'd1);
		send_gap(AUX_CALIB_HIGH - 16'd1);
		send_gap(SYNC_MAX_RESET - 16'd1);
		send_gap(16'hFFFF);
		send_gap(16'd0);
		send_gap(16'd1100);
		send_gap(16'd1900);
		send_gap(AUX_CALIB_LOW);
		send_gap(16'd1500);
		// Out-of-window gap where a sync is due drops lock.
		send_gap(16'd5000);
		send_gap(16'd12000);

		for (int p = 0; p < NUM_PHASES; p++) begin
			set_window(phase_min[p], phase_max[p]);
			no_idle = (p == 2);
			phase_sent = 0;
			while (phase_sent < phase_len[p]) begin
				if (p == 1 && !held && phase_sent >= phase_len[p] / 2) begin
					wait_drained();
					held = 1'b1;
				end
				send_random_frame();
			end
		end
		no_idle = 1'b0;

		wait_drained();
		repeat (10) @(negedge clk);
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
